@@ rtl/cpa_pkg.sv @@
package cpa_pkg;

   localparam int TIMER_BITS    = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register index, taken from paddr[2]
   localparam logic REG_FORWARD_DEFAULT  = 1'b0;
   localparam logic REG_BACKWARD_DEFAULT = 1'b1;

   typedef struct packed {
      logic entry_active;
      logic exit_active;
   } req_item_type;

   typedef struct packed {
      logic       entry_pulse;
      logic       exit_pulse;
      logic [2:0] path_mode;
   } rsp_item_type;

   typedef struct packed {
      logic dec;
      logic reload;
   } timer_ctl_type;

endpackage

@@ rtl/conduction_path_automaton.sv @@
// An accepted beat waits in the input register; its result beat is written to
// the result register once that is free. Throughput: one beat per cycle while
// rsp_ready holds; an empty input register takes a beat while a result waits.
// The mode and timer update is one pass of logic between the two registers.
// Reset (synchronous, active high) clears mode, both timers, both defaults,
// the refractory count and all valid flags.
module conduction_path_automaton
   import cpa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_item_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_item_type             rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_FWD  = 3'd1,
      MODE_BWD  = 3'd2,
      MODE_REFR = 3'd3,
      MODE_COLL = 3'd4
   } mode_type;

   mode_type        mode_ff, mode_in;
   logic [1:0]      refr_cnt_ff, refr_cnt_in;
   logic            in_valid_ff, in_valid_in;
   req_item_type    in_data_ff, in_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_data_ff, rsp_data_in;

   logic            advance;
   logic            step;
   logic            req_fire;
   logic            csr_wr;
   logic            csr_index;
   timer_ctl_type   fwd_ctl, bwd_ctl;
   logic [TIMER_BITS-1:0] fwd_default, bwd_default;
   logic            fwd_zero, bwd_zero;
   logic            entry_pulse, exit_pulse;

   // config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      unique case (csr_index)
         REG_FORWARD_DEFAULT:
            csr_prdata = {{(CSR_DATA_BITS-TIMER_BITS){1'b0}}, fwd_default};
         REG_BACKWARD_DEFAULT:
            csr_prdata = {{(CSR_DATA_BITS-TIMER_BITS){1'b0}}, bwd_default};
         default: csr_prdata = '0;
      endcase
   end

   cpa_timer u_fwd_timer (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (csr_wr && (csr_index == REG_FORWARD_DEFAULT)),
      .wr_data     (csr_pwdata[TIMER_BITS-1:0]),
      .ctl         (fwd_ctl),
      .default_val (fwd_default),
      .is_zero     (fwd_zero)
   );

   cpa_timer u_bwd_timer (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (csr_wr && (csr_index == REG_BACKWARD_DEFAULT)),
      .wr_data     (csr_pwdata[TIMER_BITS-1:0]),
      .ctl         (bwd_ctl),
      .default_val (bwd_default),
      .is_zero     (bwd_zero)
   );

   // handshake
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // one tick of the automaton
   always_comb begin
      mode_in     = mode_ff;
      refr_cnt_in = refr_cnt_ff;
      fwd_ctl     = '0;
      bwd_ctl     = '0;
      entry_pulse = 1'b0;
      exit_pulse  = 1'b0;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (in_data_ff.entry_active) begin
               mode_in = MODE_FWD;
            end else if (in_data_ff.exit_active) begin
               mode_in = MODE_BWD;
            end
         end
         MODE_FWD: begin
            if (in_data_ff.exit_active) begin
               mode_in = MODE_COLL;   // timer keeps its partial count
            end else if (fwd_zero) begin
               fwd_ctl.reload = 1'b1;
               exit_pulse     = 1'b1;
               mode_in        = MODE_REFR;
               refr_cnt_in    = '0;
            end else begin
               fwd_ctl.dec = 1'b1;
            end
         end
         MODE_BWD: begin
            if (in_data_ff.entry_active) begin
               mode_in = MODE_COLL;
            end else if (bwd_zero) begin
               bwd_ctl.reload = 1'b1;
               entry_pulse    = 1'b1;
               mode_in        = MODE_REFR;
               refr_cnt_in    = '0;
            end else begin
               bwd_ctl.dec = 1'b1;
            end
         end
         MODE_REFR: begin
            if (refr_cnt_ff == 2'd3) begin
               mode_in = MODE_IDLE;
            end else begin
               refr_cnt_in = refr_cnt_ff + 2'd1;
            end
         end
         default: begin
            mode_in     = MODE_REFR;
            refr_cnt_in = '0;
         end
      endcase
      if (!step) begin
         mode_in     = mode_ff;
         refr_cnt_in = refr_cnt_ff;
         fwd_ctl     = '0;
         bwd_ctl     = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.entry_pulse = entry_pulse;
         rsp_data_in.exit_pulse  = exit_pulse;
         rsp_data_in.path_mode   = mode_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         refr_cnt_ff  <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         refr_cnt_ff  <= refr_cnt_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.entry_pulse && rsp_data_ff.exit_pulse))
      else $error("both pulses in one result beat");

   a_pulse_refr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.entry_pulse || rsp_data_ff.exit_pulse))
      |-> (rsp_data_ff.path_mode == MODE_REFR))
      else $error("pulse without entering refractory");

   a_coll_left: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_COLL && step) |=> (mode_ff == MODE_REFR && refr_cnt_ff == 2'd0))
      else $error("collision did not move to refractory");
`endif

endmodule

@@ rtl/cpa_timer.sv @@
module cpa_timer
   import cpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [TIMER_BITS-1:0] wr_data,
   input  timer_ctl_type         ctl,
   output logic [TIMER_BITS-1:0] default_val,
   output logic                  is_zero
);

   logic [TIMER_BITS-1:0] default_ff, default_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;

   always_comb begin
      default_in = default_ff;
      timer_in   = timer_ff;
      if (wr_en) begin
         // a default write also loads the running timer
         default_in = wr_data;
         timer_in   = wr_data;
      end else if (ctl.reload) begin
         timer_in = default_ff;
      end else if (ctl.dec) begin
         timer_in = timer_ff - {{(TIMER_BITS-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff <= '0;
         timer_ff   <= '0;
      end else begin
         default_ff <= default_in;
         timer_ff   <= timer_in;
      end
   end

   assign default_val = default_ff;
   assign is_zero     = (timer_ff == '0);

endmodule

@@ bench/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cpa_pkg::*;

   localparam int  CLK_HALF_NS = 5;
   localparam int  RESET_CYCLES = 5;
   localparam int  RSP_HOLD_CYCLES = 60;
   localparam int  DRAIN_CYCLES = 6;
   localparam int  MAX_QUIET = 12;
   localparam longint RUN_LIMIT_NS = 3_000_000;

   typedef enum logic [2:0] {
      PATH_IDLE       = 3'd0,
      PATH_FORWARD    = 3'd1,
      PATH_BACKWARD   = 3'd2,
      PATH_REFRACTORY = 3'd3,
      PATH_COLLISION  = 3'd4
   } path_mode_type;

   typedef struct packed {
      req_item_type stim;
      logic         typed;
      rsp_item_type want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 23;

   // typed rows carry their result, the rest go through the predictor
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, PATH_IDLE}},
      '{'{1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, PATH_FORWARD}},
      '{'{1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, PATH_REFRACTORY}},
      '{'{1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, PATH_IDLE}},
      '{'{1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0, PATH_IDLE}},
      '{'{1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0, PATH_IDLE}},
      '{'{1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, PATH_IDLE}},
      '{'{1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, PATH_BACKWARD}},
      '{'{1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, PATH_COLLISION}},
      '{'{1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, PATH_REFRACTORY}},
      '{'{1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, PATH_REFRACTORY}},
      '{'{1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, PATH_REFRACTORY}},
      '{'{1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, PATH_REFRACTORY}},
      '{'{1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, PATH_IDLE}},
      '{'{1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, PATH_BACKWARD}},
      '{'{1'b0, 1'b0}, 1'b1, '{1'b1, 1'b0, PATH_REFRACTORY}},
      '{'{1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, PATH_IDLE}},
      '{'{1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, PATH_IDLE}},
      '{'{1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, PATH_IDLE}},
      '{'{1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, PATH_IDLE}},
      '{'{1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, PATH_FORWARD}},
      '{'{1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, PATH_COLLISION}},
      '{'{1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, PATH_REFRACTORY}}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_item_type             req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_item_type             rsp_data;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   conduction_path_automaton dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_HALF_NS) clock = ~clock;

   // predictor state
   logic [TIMER_BITS-1:0] fwd_delay = '0;
   logic [TIMER_BITS-1:0] bwd_delay = '0;
   logic [TIMER_BITS-1:0] fwd_count = '0;
   logic [TIMER_BITS-1:0] bwd_count = '0;
   logic [1:0]            refr_ticks = '0;
   path_mode_type         pred_mode = PATH_IDLE;

   rsp_item_type pending_path_results [$];
   rsp_item_type oldest_result;
   int           mismatches = 0;
   int           items_sent = 0;
   int           snd_idle_pct = 0;
   int           rcv_idle_pct = 0;
   bit           hold_rsp = 1'b0;
   int           hold_left = 0;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic rsp_item_type step_path(input req_item_type item);
      rsp_item_type res;
      res = '0;
      case (pred_mode)
         PATH_IDLE: begin
            if (item.entry_active) pred_mode = PATH_FORWARD;
            else if (item.exit_active) pred_mode = PATH_BACKWARD;
         end
         PATH_FORWARD: begin
            if (item.exit_active) begin
               pred_mode = PATH_COLLISION;
            end else if (fwd_count == '0) begin
               fwd_count = fwd_delay;
               res.exit_pulse = 1'b1;
               pred_mode = PATH_REFRACTORY;
               refr_ticks = '0;
            end else begin
               fwd_count = fwd_count - 1'b1;
            end
         end
         PATH_BACKWARD: begin
            if (item.entry_active) begin
               pred_mode = PATH_COLLISION;
            end else if (bwd_count == '0) begin
               bwd_count = bwd_delay;
               res.entry_pulse = 1'b1;
               pred_mode = PATH_REFRACTORY;
               refr_ticks = '0;
            end else begin
               bwd_count = bwd_count - 1'b1;
            end
         end
         PATH_REFRACTORY: begin
            if (refr_ticks == 2'd3) pred_mode = PATH_IDLE;
            else refr_ticks = refr_ticks + 1'b1;
         end
         default: begin
            pred_mode = PATH_REFRACTORY;
            refr_ticks = '0;
         end
      endcase
      res.path_mode = pred_mode;
      return res;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input req_item_type item, input logic typed,
                            input rsp_item_type want);
      rsp_item_type got;
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = step_path(item);
      pending_path_results.push_back(typed ? want : got);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_flags(input logic entry_on, input logic exit_on);
      req_item_type item;
      item.entry_active = entry_on;
      item.exit_active  = exit_on;
      send_item(item, 1'b0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_path_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // called at a falling edge, returns at a falling edge with the bus idle
   task automatic csr_access(input logic wr, input logic idx,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // upper data bits are random junk that the register must drop
   task automatic write_default(input logic idx, input logic [TIMER_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] rd;
      logic [CSR_DATA_BITS-1:0] wd;
      wd = {16'($urandom_range(0, 16'hFFFF)), value};
      csr_access(1'b1, idx, wd, rd);
      if (idx == REG_FORWARD_DEFAULT) begin
         fwd_delay = value;
         fwd_count = value;
      end else begin
         bwd_delay = value;
         bwd_count = value;
      end
      csr_access(1'b0, idx, '0, rd);
      if (rd !== CSR_DATA_BITS'(value))
         report_mismatch($sformatf("readback reg %0d: got %h want %h", idx, rd, value));
   endtask

   task automatic run_traffic(input int n);
      int target;
      int kind;
      int quiet;
      int pick;
      target = items_sent + n;
      while (items_sent < target) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            // well-formed: one node fires (or both), then a quiet run, maybe a collision
            pick = $urandom_range(0, 5);
            send_flags(pick <= 2 || pick == 5, pick >= 3);
            quiet = $urandom_range(0, MAX_QUIET);
            repeat (quiet) send_flags(1'b0, 1'b0);
            if ($urandom_range(0, 3) == 0) begin
               if (pick <= 2) send_flags(1'b0, 1'b1);
               else send_flags(1'b1, 1'b0);
            end
         end else begin
            repeat ($urandom_range(1, 4))
               send_flags(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // receiver: random stalls, or a long counted hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_rsp) begin
            rsp_ready <= 1'b0;
            hold_left = RSP_HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_path_results.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h", rsp_data));
         end else begin
            oldest_result = pending_path_results.pop_front();
            if (rsp_data.entry_pulse !== oldest_result.entry_pulse)
               report_mismatch($sformatf("entry_pulse got %b want %b",
                  rsp_data.entry_pulse, oldest_result.entry_pulse));
            if (rsp_data.exit_pulse !== oldest_result.exit_pulse)
               report_mismatch($sformatf("exit_pulse got %b want %b",
                  rsp_data.exit_pulse, oldest_result.exit_pulse));
            if (rsp_data.path_mode !== oldest_result.path_mode)
               report_mismatch($sformatf("path_mode got %0d want %0d",
                  rsp_data.path_mode, oldest_result.path_mode));
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      snd_idle_pct = 32;
      rcv_idle_pct = 49;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
      drain();

      write_default(REG_FORWARD_DEFAULT, 16'd3);
      write_default(REG_BACKWARD_DEFAULT, 16'd5);
      run_traffic(400);
      drain();

      // widest delays: conduction almost never completes, timers keep partial counts
      write_default(REG_FORWARD_DEFAULT, 16'hFFFF);
      write_default(REG_BACKWARD_DEFAULT, 16'hFFFF);
      run_traffic(150);
      drain();

      snd_idle_pct = 49;
      rcv_idle_pct = 32;
      write_default(REG_FORWARD_DEFAULT, 16'd0);
      write_default(REG_BACKWARD_DEFAULT, 16'd1);
      run_traffic(400);
      drain();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_default(REG_FORWARD_DEFAULT, 16'd7);
      write_default(REG_BACKWARD_DEFAULT, 16'd2);
      run_traffic(200);
      // sender pauses until every result is back
      drain();
      run_traffic(200);
      drain();

      write_default(REG_FORWARD_DEFAULT, TIMER_BITS'($urandom_range(0, 9)));
      write_default(REG_BACKWARD_DEFAULT, TIMER_BITS'($urandom_range(0, 9)));
      hold_rsp = 1'b1;
      run_traffic(200);
      drain();

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
